### rtl/src_pkg.sv
// Shared constants and types for the sample run compositor.
// No dependencies; every other rtl file refers to it by scoped names.
`timescale 1ns / 1ps
package src_pkg;
    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
    localparam int OUT_W       = SAMPLE_BITS + 1;
    localparam int DIV_STEP_W  = $clog2(SUM_W + 1);

    localparam logic [1:0] MODE_MAX    = 2'd0;
    localparam logic [1:0] MODE_MIN    = 2'd1;
    localparam logic [1:0] MODE_MEAN   = 2'd2;
    localparam logic [1:0] MODE_MEDIAN = 2'd3;

    // start request for a multi-cycle unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } med_req_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] value;
    } med_rsp_t;
endpackage

### rtl/src_ram.sv
// Sample buffer: one write port, one read port, registered read data.
// Depends on src_pkg for depth and width.
`timescale 1ns / 1ps
module src_ram (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [src_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [src_pkg::SAMPLE_BITS-1:0] wr_data,
    input  logic                           rd_en,
    input  logic [src_pkg::ADDR_W-1:0]     rd_addr,
    output logic [src_pkg::SAMPLE_BITS-1:0] rd_data
);
    logic [src_pkg::SAMPLE_BITS-1:0] mem [src_pkg::MAX_SAMPLES];
    logic [src_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    // write and read in the clocked block
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### rtl/src_div.sv
// Restoring divider for the run mean: one quotient bit per cycle.
// Depends on src_pkg for the sum and count widths.
`timescale 1ns / 1ps
module src_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [src_pkg::SUM_W-1:0]    dividend,
    input  logic [src_pkg::CNT_W-1:0]    divisor,
    output logic                         done,
    output logic [src_pkg::SUM_W-1:0]    quotient
);
    logic [src_pkg::CNT_W:0]        rem_reg, rem_next;
    logic [src_pkg::SUM_W-1:0]      quo_reg, quo_next;
    logic [src_pkg::CNT_W-1:0]      dvs_reg;
    logic [src_pkg::DIV_STEP_W-1:0] step_reg, step_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [src_pkg::CNT_W:0]        trial;

    // shift one dividend bit in, subtract where it fits
    always_comb begin
        trial     = {rem_reg[src_pkg::CNT_W-1:0], quo_reg[src_pkg::SUM_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[src_pkg::SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[src_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == src_pkg::DIV_STEP_W'(src_pkg::SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### rtl/src_median.sv
// Upper median by bitwise radix selection over the sample buffer.
// One scan of the run per sample bit; depends on src_pkg.
`timescale 1ns / 1ps
module src_median (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  src_pkg::med_req_t               req,
    output logic                            rd_en,
    output logic [src_pkg::ADDR_W-1:0]      rd_addr,
    input  logic [src_pkg::SAMPLE_BITS-1:0] rd_data,
    output src_pkg::med_rsp_t               rsp
);
    typedef enum logic [2:0] {
        M_IDLE  = 3'b001,
        M_SCAN  = 3'b010,
        M_DRAIN = 3'b100
    } med_state_t;

    med_state_t                      state_reg, state_next;
    logic [src_pkg::CNT_W-1:0]       n_reg;
    logic [src_pkg::CNT_W-1:0]       k_reg, k_next;
    logic [src_pkg::CNT_W-1:0]       c0_reg, c0_next, c0_tot;
    logic [src_pkg::CNT_W-1:0]       addr_reg, addr_next;
    logic [src_pkg::SAMPLE_BITS-1:0] pfx_reg, pfx_next;
    logic [src_pkg::SAMPLE_BITS-1:0] bit_reg, bit_next;
    logic [src_pkg::SAMPLE_BITS-1:0] mask_reg, mask_next;
    logic                            vld_reg;
    logic                            done_reg, done_next;
    logic                            hit;

    // entry shares the prefix and has a zero at the current bit
    assign hit    = vld_reg && (((rd_data ^ pfx_reg) & mask_reg) == '0)
                    && ((rd_data & bit_reg) == '0);
    assign c0_tot = c0_reg + src_pkg::CNT_W'(hit);

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        c0_next    = c0_reg;
        addr_next  = addr_reg;
        pfx_next   = pfx_reg;
        bit_next   = bit_reg;
        mask_next  = mask_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE: begin
                if (req.start) begin
                    k_next     = req.count >> 1;
                    c0_next    = '0;
                    addr_next  = '0;
                    pfx_next   = '0;
                    bit_next   = {1'b1, {(src_pkg::SAMPLE_BITS-1){1'b0}}};
                    mask_next  = '0;
                    state_next = M_SCAN;
                end
            end
            M_SCAN: begin
                c0_next = c0_tot;
                if (addr_reg == n_reg - 1'b1) begin
                    state_next = M_DRAIN;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            M_DRAIN: begin
                // settle this bit, then rescan for the next one
                if (k_reg >= c0_tot) begin
                    pfx_next = pfx_reg | bit_reg;
                    k_next   = k_reg - c0_tot;
                end
                c0_next   = '0;
                addr_next = '0;
                if (bit_reg[0]) begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end else begin
                    bit_next   = bit_reg >> 1;
                    mask_next  = mask_reg | bit_reg;
                    state_next = M_SCAN;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            vld_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg   <= (state_reg == M_SCAN);
            done_reg  <= done_next;
        end
        if (req.start && state_reg == M_IDLE) begin
            n_reg <= req.count;
        end
        k_reg    <= k_next;
        c0_reg   <= c0_next;
        addr_reg <= addr_next;
        pfx_reg  <= pfx_next;
        bit_reg  <= bit_next;
        mask_reg <= mask_next;
    end

    assign rd_en     = (state_reg == M_SCAN);
    assign rd_addr   = addr_reg[src_pkg::ADDR_W-1:0];
    assign rsp.done  = done_reg;
    assign rsp.value = pfx_reg;
endmodule

### rtl/sample_run_compositor.sv
// Sample run compositor: max, min, mean or upper median of a run of samples.
// Samples are taken one per cycle while the compositor is idle (s_tready); max,
// min and empty runs pass their result through res_reg and then out_reg after the
// closing word. Mean uses the serial divider, median one buffer scan per bit.
// Reset (aresetn, synchronous, active low) clears run stats, mode and control.
`timescale 1ns / 1ps
module sample_run_compositor (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [15:0] sample_value
    input  logic [15:0] s_tdata,
    // s_tuser: [0] has_sample
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: [16:0] composite_value, [23:17] zero
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MED  = 4'b0100,
        ST_EMIT = 4'b1000
    } top_state_t;

    top_state_t                      state_reg, state_next;
    logic [1:0]                      mode_reg;
    logic [src_pkg::CNT_W-1:0]       cnt_reg, cnt_upd;
    logic [src_pkg::SAMPLE_BITS-1:0] max_reg, max_upd, min_reg, min_upd;
    logic [src_pkg::SUM_W-1:0]       sum_reg, sum_upd;
    logic [src_pkg::OUT_W-1:0]       res_reg, res_next;
    logic [src_pkg::OUT_W-1:0]       out_reg;
    logic                            out_vld_reg;
    logic                            accept, take;
    logic                            div_start;
    logic                            div_done;
    logic [src_pkg::SUM_W-1:0]       div_quo;
    src_pkg::med_req_t               med_req;
    src_pkg::med_rsp_t               med_rsp;
    logic                            rd_en;
    logic [src_pkg::ADDR_W-1:0]      rd_addr;
    logic [src_pkg::SAMPLE_BITS-1:0] rd_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign take     = accept && s_tuser[0] && (cnt_reg < src_pkg::CNT_W'(src_pkg::MAX_SAMPLES));

    // fold an accepted sample word into the run stats while the buffer has room
    always_comb begin
        cnt_upd = cnt_reg;
        max_upd = max_reg;
        min_upd = min_reg;
        sum_upd = sum_reg;
        if (take) begin
            cnt_upd = cnt_reg + 1'b1;
            if (s_tdata > max_reg) max_upd = s_tdata;
            if (s_tdata < min_reg) min_upd = s_tdata;
            sum_upd = sum_reg + src_pkg::SUM_W'(s_tdata);
        end
    end

    // sequence the closing word to its result, through the divider or median unit where needed
    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        div_start     = 1'b0;
        med_req.start = 1'b0;
        med_req.count = cnt_upd;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tlast) begin
                    if (cnt_upd == '0) begin
                        res_next   = '1;
                        state_next = ST_EMIT;
                    end else begin
                        case (mode_reg)
                            src_pkg::MODE_MAX: begin
                                res_next   = src_pkg::OUT_W'(max_upd);
                                state_next = ST_EMIT;
                            end
                            src_pkg::MODE_MIN: begin
                                res_next   = src_pkg::OUT_W'(min_upd);
                                state_next = ST_EMIT;
                            end
                            src_pkg::MODE_MEAN: begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                            default: begin
                                med_req.start = 1'b1;
                                state_next    = ST_MED;
                            end
                        endcase
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = div_quo[src_pkg::OUT_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            ST_MED: begin
                if (med_rsp.done) begin
                    res_next   = src_pkg::OUT_W'(med_rsp.value);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!out_vld_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= src_pkg::MODE_MAX;
            cnt_reg     <= '0;
            max_reg     <= '0;
            min_reg     <= '1;
            sum_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && !paddr[2]) begin
                mode_reg <= pwdata[1:0];
            end
            // clear the run on its closing word
            if (accept && s_tlast) begin
                cnt_reg <= '0;
                max_reg <= '0;
                min_reg <= '1;
                sum_reg <= '0;
            end else begin
                cnt_reg <= cnt_upd;
                max_reg <= max_upd;
                min_reg <= min_upd;
                sum_reg <= sum_upd;
            end
            if (state_reg == ST_EMIT && (!out_vld_reg || m_tready)) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
        res_reg <= res_next;
        if (state_reg == ST_EMIT && (!out_vld_reg || m_tready)) begin
            out_reg <= res_reg;
        end
    end

    src_ram u_ram (
        .aclk    (aclk),
        .wr_en   (take),
        .wr_addr (cnt_reg[src_pkg::ADDR_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    src_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_upd),
        .divisor  (cnt_upd),
        .done     (div_done),
        .quotient (div_quo)
    );

    src_median u_med (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (med_req),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .rsp     (med_rsp)
    );

    assign m_tdata  = {7'b0, out_reg};
    assign m_tvalid = out_vld_reg;
    assign prdata   = paddr[2] ? 32'd0 : {30'd0, mode_reg};
    assign pready   = 1'b1;

    // units report only while the sequencer waits for them; the run count never exceeds MAX_SAMPLES
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV) else $error("divider done out of turn");
    a_med_done: assert property (@(posedge aclk) disable iff (!aresetn)
        med_rsp.done |-> state_reg == ST_MED) else $error("median done out of turn");
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= src_pkg::CNT_W'(src_pkg::MAX_SAMPLES)) else $error("count overflow");
endmodule
